// ===== design/hri_pkg.sv =====
package hri_pkg;

    // Default geometry
    localparam int INDEX_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 32;

    // Fixed port widths
    localparam int PORT_W  = 32;
    localparam int RADIX_W = 8;

    // Radix register reset value and smallest usable base
    localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;

    // Link between neighboring cells: one division wavefront and its partial remainder
    typedef struct packed {
        logic               valid;
        logic [RADIX_W-1:0] rem;
    } t_link;

    // Control sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

endpackage

// ===== design/hri_cell.sv =====
// One bit position of the index. Each passing wavefront performs one restoring
// division step by the radix: the bit is replaced by a quotient bit and the
// new partial remainder moves on to the next lower cell.
module hri_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic                         i_load_bit,
    input  logic [hri_pkg::RADIX_W-1:0]  i_radix,
    input  hri_pkg::t_link               i_link,
    output hri_pkg::t_link               o_link
);

    logic                          r_bit;
    logic                          r_valid;
    logic [hri_pkg::RADIX_W-1:0]   r_rem;

    logic [hri_pkg::RADIX_W:0]     w_part;
    logic [hri_pkg::RADIX_W:0]     w_div;
    logic                          w_ge;
    logic [hri_pkg::RADIX_W:0]     w_next;

    // Shift in this bit, compare against the radix, restore if below
    assign w_part = {i_link.rem, r_bit};
    assign w_div  = {1'b0, i_radix};
    assign w_ge   = (w_part >= w_div);
    assign w_next = w_ge ? (w_part - w_div) : w_part;

    // Wavefront token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_link.valid;
        end
    end

    // Index bit and outgoing remainder
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bit <= i_load_bit;
        end else if (i_link.valid) begin
            r_bit <= w_ge;
            r_rem <= w_next[hri_pkg::RADIX_W-1:0];
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.rem   = r_rem;

endmodule

// ===== design/hri_chain.sv =====
// Row of bit cells holding the index. A wavefront entering at the top cell
// divides the stored value by the radix on its way down; wavefronts follow
// each other every cycle, so one base-radix digit (least significant first)
// leaves the bottom cell per cycle once the row is filled.
module hri_chain #(
    parameter int IDX_W = hri_pkg::PORT_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [IDX_W-1:0]             i_index,
    input  logic [hri_pkg::RADIX_W-1:0]  i_radix,
    input  logic                         i_issue,
    output hri_pkg::t_link               o_digit
);

    hri_pkg::t_link w_link [IDX_W+1];

    // New wavefront starts with a zero remainder
    assign w_link[IDX_W].valid = i_issue;
    assign w_link[IDX_W].rem   = '0;

    for (genvar gi = 0; gi < IDX_W; gi++) begin : g_cell
        hri_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (i_load),
            .i_load_bit (i_index[gi]),
            .i_radix    (i_radix),
            .i_link     (w_link[gi+1]),
            .o_link     (w_link[gi])
        );
    end

    assign o_digit = w_link[0];

endmodule

// ===== design/hri_divider.sv =====
// Restoring long division: quotient = floor(num * 2^FRAC_W / den), num < den.
// One quotient bit per cycle; done pulses once.
module hri_divider #(
    parameter int DEN_W  = 40,
    parameter int FRAC_W = hri_pkg::FRACTION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DEN_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [FRAC_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [FRAC_W-1:0] r_quo;

    logic [DEN_W:0]    w_shift;
    logic [DEN_W:0]    w_den_ext;
    logic              w_bit;

    // Remainder stays below den: the doubled value needs one extra bit,
    // the restored remainder fits back in DEN_W bits
    assign w_shift   = {r_rem, 1'b0};
    assign w_den_ext = {1'b0, r_den};
    assign w_bit     = (w_shift >= w_den_ext);

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= DEN_W'(w_bit ? (w_shift - w_den_ext) : w_shift);
            r_quo <= {r_quo[FRAC_W-2:0], w_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/halton_radical_inverse.sv =====
// Radical inverse (van der Corput / Halton point) of a sequence index.
// Input channel: i_in_valid / o_in_stall carry one word, i_sample_index.
// Output channel: o_out_valid / i_out_stall carry one word, o_point_value,
// the index's base-radix digits mirrored about the radix point, as an
// unsigned Q0.FRACTION_BITS fraction truncated toward zero (low 32 bits).
// Config: i_cfg_wr_en writes i_cfg_wr_data to the radix; write only while
// idle. A radix of 0 or 1 acts as 2.
// Each word is processed in order: wavefronts pass down the bit-cell row of
// IDX_W cells (IDX_W is the index width used, the min of INDEX_BITS and 32),
// each base-radix digit of the index is then folded in, one more digit finds
// the end, and the long divider then yields the fraction bits.
// One word is in flight at a time; the next word is taken once the result
// sits in the output register, even while the receiver stalls it.
// A stalled result holds in the output register; a new result waits in the
// block until that register frees up.
// Reset sets the radix to 2 and empties the block; no word is pending.
module halton_radical_inverse #(
    parameter int INDEX_BITS    = hri_pkg::INDEX_BITS_DEF,
    parameter int FRACTION_BITS = hri_pkg::FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [hri_pkg::RADIX_W-1:0]  i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [hri_pkg::PORT_W-1:0]   i_sample_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [hri_pkg::PORT_W-1:0]   o_point_value
);

    localparam int IDX_W = (INDEX_BITS < hri_pkg::PORT_W) ? INDEX_BITS : hri_pkg::PORT_W;
    localparam int DW    = IDX_W + hri_pkg::RADIX_W;

    hri_pkg::t_state                r_state;
    hri_pkg::t_state                n_state;

    logic [hri_pkg::RADIX_W-1:0]    r_radix;
    logic [IDX_W-1:0]               r_index;
    logic [DW-1:0]                  r_num;
    logic [DW-1:0]                  r_den;
    logic                           r_out_valid;
    logic [hri_pkg::PORT_W-1:0]     r_point;

    logic [hri_pkg::RADIX_W-1:0]    w_base;
    logic                           w_in_acc;
    logic                           w_out_free;
    logic                           w_take;
    logic                           w_issue;
    logic                           w_div_start;
    logic                           w_out_load;
    logic                           w_div_done;
    logic [FRACTION_BITS-1:0]       w_quo;
    logic [DW+hri_pkg::RADIX_W-1:0] w_num_mul;
    logic [DW+hri_pkg::RADIX_W-1:0] w_den_mul;
    hri_pkg::t_link                 w_digit;

    // Radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= hri_pkg::RADIX_RESET;
        end else if (i_cfg_wr_en) begin
            r_radix <= i_cfg_wr_data;
        end
    end

    assign w_base = (r_radix < hri_pkg::RADIX_MIN) ? hri_pkg::RADIX_MIN : r_radix;

    // Handshakes
    assign o_in_stall = (r_state != hri_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Digit j counts while radix^j <= index; later digits are leading zeros
    assign w_take = (r_den <= {{hri_pkg::RADIX_W{1'b0}}, r_index});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hri_pkg::ST_IDLE: begin
                if (w_in_acc) n_state = hri_pkg::ST_DIGITS;
            end
            hri_pkg::ST_DIGITS: begin
                if (w_digit.valid && !w_take) n_state = hri_pkg::ST_DIVIDE;
            end
            hri_pkg::ST_DIVIDE: begin
                if (w_div_done) n_state = hri_pkg::ST_FINISH;
            end
            hri_pkg::ST_FINISH: begin
                if (w_out_free) n_state = hri_pkg::ST_IDLE;
            end
            default: n_state = hri_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        w_issue     = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            hri_pkg::ST_IDLE: begin
            end
            hri_pkg::ST_DIGITS: begin
                w_issue     = 1'b1;
                w_div_start = w_digit.valid && !w_take;
            end
            hri_pkg::ST_DIVIDE: begin
            end
            hri_pkg::ST_FINISH: begin
                w_out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hri_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Digit generation
    hri_chain #(
        .IDX_W (IDX_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_acc),
        .i_index (i_sample_index[IDX_W-1:0]),
        .i_radix (w_base),
        .i_issue (w_issue),
        .o_digit (w_digit)
    );

    // Mirrored numerator and denominator radix^digits
    assign w_num_mul = r_num * w_base;
    assign w_den_mul = r_den * w_base;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_index <= i_sample_index[IDX_W-1:0];
            r_num   <= '0;
            r_den   <= DW'(1);
        end else if ((r_state == hri_pkg::ST_DIGITS) && w_digit.valid && w_take) begin
            r_num <= w_num_mul[DW-1:0] + DW'(w_digit.rem);
            r_den <= w_den_mul[DW-1:0];
        end
    end

    // Final scaling
    hri_divider #(
        .DEN_W  (DW),
        .FRAC_W (FRACTION_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_num      (r_num),
        .i_den      (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_point <= hri_pkg::PORT_W'(w_quo);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_value = r_point;

endmodule

// ===== test/hri_point_checker.sv =====
// Watches both channels of the radical inverse block, predicts each point
// from the accepted index and the current radix, and compares the results.
module hri_point_checker #(
    parameter int INDEX_BITS    = hri_pkg::INDEX_BITS_DEF,
    parameter int FRACTION_BITS = hri_pkg::FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [hri_pkg::RADIX_W-1:0]  i_cfg_wr_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [hri_pkg::PORT_W-1:0]   i_sample_index,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [hri_pkg::PORT_W-1:0]   i_point_value,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [hri_pkg::PORT_W-1:0]  index;
        logic [hri_pkg::RADIX_W-1:0] radix;
        logic [hri_pkg::PORT_W-1:0]  point;
    } t_point_expect;

    t_point_expect               point_queue[$];
    t_point_expect               head;
    t_point_expect               fresh;
    logic [hri_pkg::RADIX_W-1:0] radix_reg;

    // Mirror the base digits of the index, then long-divide R / D into
    // FRACTION_BITS fraction bits; exact, truncated toward zero
    function automatic logic [hri_pkg::PORT_W-1:0] radical_point(
        input logic [hri_pkg::PORT_W-1:0]  index,
        input logic [hri_pkg::RADIX_W-1:0] radix
    );
        logic [63:0] base;
        logic [63:0] rest;
        logic [63:0] numer;
        logic [63:0] denom;
        logic [63:0] rem;
        logic [63:0] quot;
        logic [63:0] idx_mask;
        int          bit_n;
        idx_mask = (INDEX_BITS >= 64) ? '1 : ((64'd1 << INDEX_BITS) - 64'd1);
        base  = (radix < hri_pkg::RADIX_MIN) ? 64'(hri_pkg::RADIX_MIN) : 64'(radix);
        rest  = 64'(index) & idx_mask;
        numer = 64'd0;
        denom = 64'd1;
        quot  = 64'd0;
        while (rest != 64'd0) begin
            numer = numer * base + (rest % base);
            denom = denom * base;
            rest  = rest / base;
        end
        rem = numer;
        for (bit_n = 0; bit_n < FRACTION_BITS; bit_n++) begin
            rem  = rem << 1;
            quot = quot << 1;
            if (rem >= denom) begin
                rem  = rem - denom;
                quot = quot | 64'd1;
            end
        end
        return quot[hri_pkg::PORT_W-1:0];
    endfunction

    // Result check first, then new expectation, then radix write
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_reg    = hri_pkg::RADIX_RESET;
            o_fail_count = 0;
            point_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (point_queue.size() == 0) begin
                    $display("%0t: unexpected point_value word, expected none, actual %h",
                             $time, i_point_value);
                    o_fail_count++;
                end else begin
                    head = point_queue.pop_front();
                    if (head.point !== i_point_value) begin
                        $display({"%0t: point_value mismatch (index %h radix %0d): ",
                                  "expected %h, actual %h"},
                                 $time, head.index, head.radix, head.point,
                                 i_point_value);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fresh.index = i_sample_index;
                fresh.radix = radix_reg;
                fresh.point = radical_point(i_sample_index, radix_reg);
                point_queue = {point_queue, fresh};
            end
            if (i_cfg_wr_en) begin
                radix_reg = i_cfg_wr_data;
            end
        end
        o_pending = point_queue.size();
    end

endmodule

// ===== test/halton_radical_inverse_tb.sv =====
module halton_radical_inverse_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 5000;
    localparam int END_CYCLES  = 120;
    localparam int PHASE_ITEMS = 36;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_LONG,
        STALL_RARE
    } t_stall_mode;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_wr_en;
    logic [hri_pkg::RADIX_W-1:0]  i_cfg_wr_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [hri_pkg::PORT_W-1:0]   i_sample_index;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [hri_pkg::PORT_W-1:0]   o_point_value;

    int                  fail_count;
    int                  pending;
    int                  idle_count;
    t_stall_mode         stall_mode;
    int                  mode_left;
    int                  level_left;
    logic                stall_level;

    halton_radical_inverse DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_index (i_sample_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_point_value  (o_point_value)
    );

    hri_point_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_sample_index (i_sample_index),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_point_value  (o_point_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver stall: modes of random length
    initial begin
        i_out_stall = 1'b0;
        mode_left   = 0;
        level_left  = 0;
        stall_level = 1'b0;
        stall_mode  = STALL_NONE;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE: begin
                    i_out_stall <= 1'b0;
                end
                STALL_COIN: begin
                    i_out_stall <= ($urandom_range(0, 1) == 1);
                end
                STALL_LONG: begin
                    if (level_left == 0) begin
                        level_left  = $urandom_range(1, 16);
                        stall_level = ~stall_level;
                    end
                    level_left--;
                    i_out_stall <= stall_level;
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // Watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_count = 0;
        end else begin
            idle_count++;
        end
        if (idle_count >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one index word and hold it until accepted
    task automatic send_index(input logic [hri_pkg::PORT_W-1:0] index);
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_sample_index <= index;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic idle_cycles(input int count);
        repeat (count) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Hold off until every expected point has come back
    task automatic drain_points();
        idle_cycles(1);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_radix(input logic [hri_pkg::RADIX_W-1:0] radix);
        drain_points();
        idle_cycles(4);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= radix;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Half full-width random indices, the rest small values or bit patterns
    function automatic logic [hri_pkg::PORT_W-1:0] random_index();
        case ($urandom_range(0, 7))
            0:       return hri_pkg::PORT_W'($urandom_range(0, 255));
            1:       return hri_pkg::PORT_W'($urandom_range(0, 65535));
            2:       return '1 >> $urandom_range(0, hri_pkg::PORT_W - 1);
            3:       return hri_pkg::PORT_W'(1) << $urandom_range(0, hri_pkg::PORT_W - 1);
            default: return hri_pkg::PORT_W'($urandom());
        endcase
    endfunction

    // Bursts of random length with random gaps, sometimes back to back
    task automatic random_phase(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
            while (burst > 0 && sent < count) begin
                send_index(random_index());
                sent++;
                burst--;
            end
            if ($urandom_range(0, 29) == 0) begin
                drain_points();
            end else if ($urandom_range(0, 3) != 0) begin
                idle_cycles($urandom_range(1, 8));
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_in_valid     = 1'b0;
        i_sample_index = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: base 2 extremes and bit patterns
        write_radix(8'd2);
        send_index(32'h0000_0000);
        send_index(32'h0000_0001);
        send_index(32'h0000_0002);
        send_index(32'h0000_0003);
        send_index(32'h8000_0000);
        send_index(32'hFFFF_FFFF);
        send_index(32'hAAAA_AAAA);
        send_index(32'h5555_5555);
        send_index(32'h7FFF_FFFF);
        random_phase(PHASE_ITEMS);

        // Widest base: digit boundaries
        write_radix(8'd255);
        send_index(32'd0);
        send_index(32'd254);
        send_index(32'd255);
        send_index(32'd65025);
        send_index(32'd4228250625);
        send_index(32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);

        // Radix of zero or one acts as base 2
        write_radix(8'd0);
        send_index(32'd1);
        send_index(32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);
        write_radix(8'd1);
        send_index(32'd3);
        random_phase(PHASE_ITEMS);

        // Base 3: largest power below 2^32
        write_radix(8'd3);
        send_index(32'd3486784401);
        send_index(32'd3486784400);
        random_phase(PHASE_ITEMS);

        write_radix(8'd254);
        random_phase(PHASE_ITEMS);
        write_radix(8'd5);
        random_phase(PHASE_ITEMS);
        write_radix(8'd7);
        random_phase(PHASE_ITEMS);
        write_radix(8'd13);
        random_phase(PHASE_ITEMS);
        write_radix(hri_pkg::RADIX_W'($urandom_range(2, 255)));
        random_phase(PHASE_ITEMS);
        write_radix(hri_pkg::RADIX_W'($urandom_range(0, 255)));
        random_phase(PHASE_ITEMS);

        // Let the last points come back, then a margin for strays
        drain_points();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== halton_radical_inverse.f =====
design/hri_pkg.sv
design/hri_cell.sv
design/hri_chain.sv
design/hri_divider.sv
design/halton_radical_inverse.sv
test/hri_point_checker.sv
test/halton_radical_inverse_tb.sv
